// File: sv/mvtm_pkg.sv
// Shared types and constants for the multi-voice tone mixer.
// Used by mvtm_ctrl, mvtm_dp and the top level; depends on nothing.
`default_nettype none

package mvtm_pkg;

	localparam int VOICES_DEF     = 8;
	localparam int SINE_DEPTH_DEF = 256;

	localparam logic [31:0] Q30_ONE = 32'd1073741824;
	localparam logic [31:0] POLY_A  = 32'd1686629713;
	localparam logic [31:0] POLY_B  = 32'd693598668;
	localparam logic [31:0] POLY_C  = 32'd85569306;
	localparam logic [31:0] POLY_D  = 32'd5026994;
	localparam logic [31:0] POLY_E  = 32'd172272;
	// Horner constants in the order they are applied after E
	localparam logic [31:0] POLY_K [4] = '{POLY_D, POLY_C, POLY_B, POLY_A};

	localparam logic [2:0] FMT_S8  = 3'd0;
	localparam logic [2:0] FMT_U8  = 3'd1;
	localparam logic [2:0] FMT_S16 = 3'd2;
	localparam logic [2:0] FMT_U16 = 3'd3;
	localparam logic [2:0] FMT_S32 = 3'd4;
	localparam logic [2:0] FMT_U32 = 3'd5;

	localparam logic REG_RUNNING = 1'b0;
	localparam logic REG_FORMAT  = 1'b1;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	localparam logic [1:0] SHAPE_SINE = 2'd0;
	localparam logic [1:0] SHAPE_SQR  = 2'd1;
	localparam logic [1:0] SHAPE_TRI  = 2'd2;
	localparam logic [1:0] SHAPE_SAW  = 2'd3;

	typedef struct packed {
		logic [7:0]  tag;
		logic [1:0]  shape;
		logic [31:0] step;
		logic [15:0] offset;
		logic [15:0] level;
		logic [31:0] phase;
		logic [23:0] pos;
		logic [23:0] len;
	} voice_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD, ST_CHK, ST_LOAD, ST_WAVE, ST_SK, ST_SQ, ST_SB, ST_SX,
		ST_SANG, ST_SFOLD, ST_ST2, ST_SPOLY, ST_SMAG, ST_LVL, ST_ACC, ST_NEXT,
		ST_SUM, ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_SCAN, OP_LOAD, OP_PHASE, OP_WAVE, OP_SK, OP_SQ, OP_SB, OP_SX,
		OP_SANG, OP_SFOLD, OP_ST2, OP_SPOLY, OP_SMAG, OP_LVL, OP_ACC, OP_SUM
	} dp_op_t;

	typedef struct packed {
		logic       latch_in;
		logic       idx_clr;
		logic       idx_inc;
		logic       mem_rd;
		logic       out_load;
		dp_op_t     op;
		logic [1:0] poly_sel;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic last;
		logic cur_active;
		logic is_sine;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: sv/multi_voice_tone_mixer.sv
// Polyphonic tone mixer. A start item (kind 1) loads a tone into the voice
// already playing its tag or into the lowest free voice and gives no result.
// A sample tick (kind 0) gives one result item: the sine reduction and
// polynomial and the amplitude products go through one shared 34x34
// multiplier, one product a cycle, while a sequencer walks the voice memory
// one voice at a time. The result sits in an output register, so the next
// item is taken while it waits.
// Configuration over the APB port: running at 0x0, sample_format at 0x4.
`default_nettype none

module multi_voice_tone_mixer #(
	parameter int VOICES           = mvtm_pkg::VOICES_DEF,
	parameter int SINE_TABLE_DEPTH = mvtm_pkg::SINE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  tone_tag,
	input  wire logic [1:0]  shape,
	input  wire logic [31:0] phase_step,
	input  wire logic [15:0] phase_offset,
	input  wire logic [15:0] amplitude,
	input  wire logic [23:0] duration,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      sample_bits,
	output logic             clipped,
	output logic             any_playing
);
	import mvtm_pkg::*;

	logic       running_q;
	logic [2:0] format_q;
	cmd_t       cmd;
	sts_t       sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b1;
			format_q  <= FMT_S16;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_RUNNING) running_q <= pwdata[0];
			else format_q <= pwdata[2:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_FORMAT) prdata = {29'd0, format_q};
		else prdata = {31'd0, running_q};
	end

	mvtm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mvtm_dp #(
		.VOICES           (VOICES),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.tone_tag      (tone_tag),
		.shape         (shape),
		.phase_step    (phase_step),
		.phase_offset  (phase_offset),
		.amplitude     (amplitude),
		.duration      (duration),
		.running       (running_q),
		.sample_format (format_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sample_bits   (sample_bits),
		.clipped       (clipped),
		.any_playing   (any_playing)
	);

endmodule

`default_nettype wire

// File: sv/mvtm_ctrl.sv
// Sequencer for the tone mixer: walks the voices and steps the shared multiplier.
// Depends on mvtm_pkg; drives mvtm_dp through cmd_t and reads sts_t.
`default_nettype none

module mvtm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire mvtm_pkg::sts_t sts,
	output mvtm_pkg::cmd_t     cmd
);
	import mvtm_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] pcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pcnt_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ST2) pcnt_q <= 2'd0;
			else if (state_q == ST_SPOLY) pcnt_q <= pcnt_q + 2'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_RD;
			ST_RD:    state_d = ST_CHK;
			ST_CHK: begin
				if (sts.kind == KIND_START) state_d = sts.last ? ST_LOAD : ST_RD;
				else if (!sts.cur_active) state_d = ST_NEXT;
				else if (sts.is_sine) state_d = ST_SK;
				else state_d = ST_WAVE;
			end
			ST_LOAD:  state_d = ST_IDLE;
			ST_WAVE:  state_d = ST_LVL;
			ST_SK:    state_d = ST_SQ;
			ST_SQ:    state_d = ST_SB;
			ST_SB:    state_d = ST_SX;
			ST_SX:    state_d = ST_SANG;
			ST_SANG:  state_d = ST_SFOLD;
			ST_SFOLD: state_d = ST_ST2;
			ST_ST2:   state_d = ST_SPOLY;
			ST_SPOLY: if (pcnt_q == 2'd3) state_d = ST_SMAG;
			ST_SMAG:  state_d = ST_LVL;
			ST_LVL:   state_d = ST_ACC;
			ST_ACC:   state_d = ST_NEXT;
			ST_NEXT:  state_d = sts.last ? ST_SUM : ST_RD;
			ST_SUM:   state_d = ST_OUT;
			ST_OUT:   if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.op       = OP_NOP;
		cmd.poly_sel = pcnt_q;
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
				cmd.idx_clr  = in_valid;
			end
			ST_RD:    cmd.mem_rd = 1'b1;
			ST_CHK: begin
				if (sts.kind == KIND_START) begin
					cmd.op      = OP_SCAN;
					cmd.idx_inc = !sts.last;
				end else begin
					cmd.op = OP_PHASE;
				end
			end
			ST_LOAD:  cmd.op = OP_LOAD;
			ST_WAVE:  cmd.op = OP_WAVE;
			ST_SK:    cmd.op = OP_SK;
			ST_SQ:    cmd.op = OP_SQ;
			ST_SB:    cmd.op = OP_SB;
			ST_SX:    cmd.op = OP_SX;
			ST_SANG:  cmd.op = OP_SANG;
			ST_SFOLD: cmd.op = OP_SFOLD;
			ST_ST2:   cmd.op = OP_ST2;
			ST_SPOLY: cmd.op = OP_SPOLY;
			ST_SMAG:  cmd.op = OP_SMAG;
			ST_LVL:   cmd.op = OP_LVL;
			ST_ACC:   cmd.op = OP_ACC;
			ST_NEXT:  cmd.idx_inc = !sts.last;
			ST_SUM:   cmd.op = OP_SUM;
			ST_OUT:   cmd.out_load = sts.out_free;
			default:  cmd.op = OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

// File: sv/mvtm_dp.sv
// Datapath of the tone mixer: voice memory, active bits, shared multiplier,
// accumulator, saturation and output register. Depends on mvtm_pkg.
`default_nettype none

module mvtm_dp #(
	parameter int VOICES           = mvtm_pkg::VOICES_DEF,
	parameter int SINE_TABLE_DEPTH = mvtm_pkg::SINE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mvtm_pkg::cmd_t cmd,
	output mvtm_pkg::sts_t      sts,
	input  wire logic           kind,
	input  wire logic [7:0]     tone_tag,
	input  wire logic [1:0]     shape,
	input  wire logic [31:0]    phase_step,
	input  wire logic [15:0]    phase_offset,
	input  wire logic [15:0]    amplitude,
	input  wire logic [23:0]    duration,
	input  wire logic           running,
	input  wire logic [2:0]     sample_format,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [31:0]         sample_bits,
	output logic                clipped,
	output logic                any_playing
);
	import mvtm_pkg::*;

	localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int KW    = $clog2(SINE_TABLE_DEPTH);
	localparam int ACC_W = 33 + VW;
	localparam int VAL_W = ACC_W - 15;
	localparam longint unsigned QD   = (64'd1 << 32) / SINE_TABLE_DEPTH;
	localparam longint unsigned RREM = (64'd1 << 32) % SINE_TABLE_DEPTH;
	// reciprocal for an exact floor(x / depth) with x below depth squared
	localparam longint unsigned MREC =
		((64'd1 << 36) + SINE_TABLE_DEPTH - 1) / SINE_TABLE_DEPTH;

	function automatic logic [15:0] q30_to_q15(input logic [31:0] mag);
		logic [32:0] s;
		logic [17:0] v;
		s = {1'b0, mag} + 33'd16384;
		v = s[32:15];
		return (v > 18'd32767) ? 16'd32767 : v[15:0];
	endfunction

	voice_t mem [VOICES];
	voice_t rd_q;
	voice_t mem_wd;
	logic   mem_we;
	logic [VW-1:0] mem_wa;

	logic [VOICES-1:0] active_q;
	logic [VW-1:0]     idx_q;

	logic        kind_q;
	logic [7:0]  tag_q;
	logic [1:0]  shape_q;
	logic [31:0] step_q;
	logic [15:0] off_q;
	logic [15:0] amp_q;
	logic [23:0] dur_q;

	logic          match_q, free_q;
	logic [VW-1:0] match_idx_q, free_idx_q, slot;

	logic [31:0] p_q, base_q;
	logic [KW-1:0] k_q;
	logic [30:0] t_q, t2_q, t_fold;
	logic        neg_q;
	logic [15:0] vmag_q;
	logic        vneg_q;
	logic [67:0] prod_q;
	logic [33:0] mul_a, mul_b;
	logic [31:0] r_w;

	logic signed [ACC_W-1:0] acc_q, acc_add;
	logic [ACC_W-1:0]        acc_mag;
	logic signed [VAL_W-1:0] val_q, val_w;
	logic [VAL_W-1:0]        qmag;

	logic        out_valid_q, clip_q, any_q;
	logic [31:0] bits_q;

	logic signed [33:0] v34, lo, hi, sat;
	logic [31:0]        mask;
	logic               clip_w;

	logic [15:0] wmag;
	logic        wneg;
	logic [15:0] saw_v;

	assign sts.kind       = kind_q;
	assign sts.last       = (idx_q == VW'(VOICES - 1));
	assign sts.cur_active = active_q[idx_q];
	assign sts.is_sine    = (rd_q.shape == SHAPE_SINE);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign slot = match_q ? match_idx_q : free_idx_q;

	// quarter-wave fold of the current phase
	always_comb begin
		t_fold = {1'b0, p_q[29:0]};
		if (p_q[30]) t_fold = Q30_ONE[30:0] - {1'b0, p_q[29:0]};
	end

	// direct wave values for square, triangle and sawtooth
	always_comb begin
		saw_v = ~p_q[31:16] + 16'd1;
		wmag  = 16'd0;
		wneg  = 1'b0;
		case (rd_q.shape)
			SHAPE_SQR: begin
				wmag = 16'd32767;
				wneg = (p_q > 32'h8000_0000);
			end
			SHAPE_SAW: begin
				wneg = p_q[31];
				wmag = p_q[31] ? saw_v : p_q[31:16];
			end
			default: begin
				wmag = q30_to_q15({1'b0, t_fold});
				wneg = p_q[31];
			end
		endcase
	end

	assign r_w = POLY_K[cmd.poly_sel] - prod_q[61:30];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SK: begin
				mul_a = 34'(p_q);
				mul_b = 34'(SINE_TABLE_DEPTH);
			end
			OP_SQ: begin
				mul_a = 34'(prod_q[32 +: KW]);
				mul_b = 34'(QD);
			end
			OP_SB: begin
				mul_a = 34'(k_q);
				mul_b = 34'(RREM);
			end
			OP_SX: begin
				mul_a = 34'(prod_q[23:0]);
				mul_b = 34'(MREC);
			end
			OP_SFOLD: begin
				mul_a = 34'(t_fold);
				mul_b = 34'(t_fold);
			end
			OP_ST2: begin
				mul_a = 34'(prod_q[60:30]);
				mul_b = 34'(POLY_E);
			end
			OP_SPOLY: begin
				mul_a = (cmd.poly_sel == 2'd3) ? 34'(t_q) : 34'(t2_q);
				mul_b = 34'(r_w);
			end
			OP_LVL: begin
				mul_a = 34'(vmag_q);
				mul_b = 34'(rd_q.level);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = rd_q;
		if (cmd.op == OP_LOAD) begin
			mem_we = match_q || free_q;
			mem_wa = slot;
			mem_wd = '{tag: tag_q, shape: shape_q, step: step_q, offset: off_q,
				level: amp_q, phase: 32'd0, pos: 24'd0, len: dur_q};
		end else if (cmd.op == OP_ACC) begin
			mem_we       = (rd_q.pos < rd_q.len);
			mem_wd.pos   = rd_q.pos + 24'd1;
			mem_wd.phase = rd_q.phase + rd_q.step;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.mem_rd) rd_q <= mem[idx_q];
	end

	assign acc_add = vneg_q ? -$signed(ACC_W'(prod_q[31:0])) : $signed(ACC_W'(prod_q[31:0]));
	assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign qmag    = acc_mag[ACC_W-1:15];
	assign val_w   = acc_q[ACC_W-1] ? -$signed(qmag) : $signed(qmag);

	// payload registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.latch_in) begin
			kind_q  <= kind;
			tag_q   <= tone_tag;
			shape_q <= shape;
			step_q  <= phase_step;
			off_q   <= phase_offset;
			amp_q   <= amplitude;
			dur_q   <= duration;
		end
		case (cmd.op)
			OP_PHASE: p_q <= rd_q.phase - {rd_q.offset, 16'd0};
			OP_WAVE: begin
				vmag_q <= wmag;
				vneg_q <= wneg;
			end
			OP_SQ:    k_q <= prod_q[32 +: KW];
			OP_SB:    base_q <= prod_q[31:0];
			OP_SANG:  p_q <= base_q + prod_q[67:36];
			OP_SFOLD: begin
				t_q   <= t_fold;
				neg_q <= p_q[31];
			end
			OP_ST2:   t2_q <= prod_q[60:30];
			OP_SMAG: begin
				vmag_q <= q30_to_q15(prod_q[61:30]);
				vneg_q <= neg_q;
			end
			OP_SUM:   val_q <= val_w;
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			bits_q <= sat[31:0] & mask;
			clip_q <= clip_w;
			any_q  <= (|active_q) && running;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			idx_q       <= '0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			match_idx_q <= '0;
			free_idx_q  <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + VW'(1);
			if (cmd.latch_in) begin
				match_q <= 1'b0;
				free_q  <= 1'b0;
				acc_q   <= '0;
			end
			if (cmd.op == OP_SCAN) begin
				if (active_q[idx_q] && rd_q.tag == tag_q && !match_q) begin
					match_q     <= 1'b1;
					match_idx_q <= idx_q;
				end
				if (!active_q[idx_q] && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_q;
				end
			end
			if (cmd.op == OP_LOAD && (match_q || free_q)) active_q[slot] <= 1'b1;
			if (cmd.op == OP_ACC) begin
				acc_q <= acc_q + acc_add;
				if (rd_q.pos >= rd_q.len) active_q[idx_q] <= 1'b0;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// saturation to the configured format
	always_comb begin
		v34 = 34'(val_q);
		case (sample_format)
			FMT_S8: begin
				lo = -34'sd128;
				hi = 34'sd127;
				mask = 32'h0000_00FF;
			end
			FMT_U8: begin
				lo = 34'sd0;
				hi = 34'sd255;
				mask = 32'h0000_00FF;
			end
			FMT_U16: begin
				lo = 34'sd0;
				hi = 34'sd65535;
				mask = 32'h0000_FFFF;
			end
			FMT_S32: begin
				lo = -34'sd2147483648;
				hi = 34'sd2147483647;
				mask = 32'hFFFF_FFFF;
			end
			FMT_U32: begin
				lo = 34'sd0;
				hi = 34'sd4294967295;
				mask = 32'hFFFF_FFFF;
			end
			default: begin
				lo = -34'sd32768;
				hi = 34'sd32767;
				mask = 32'h0000_FFFF;
			end
		endcase
		sat    = v34;
		clip_w = 1'b0;
		if (v34 < lo) begin
			sat    = lo;
			clip_w = 1'b1;
		end
		if (v34 > hi) begin
			sat    = hi;
			clip_w = 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_bits = bits_q;
	assign clipped     = clip_q;
	assign any_playing = any_q;

	a_load_sets_active: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD && (match_q || free_q)) |=> active_q[$past(slot)])
		else $error("start item did not claim a voice");

	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ST2) |-> (t_q <= Q30_ONE[30:0]))
		else $error("folded phase above quarter wave");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !out_ready))
		else $error("result item overwritten before taken");

endmodule

`default_nettype wire
